FILE: hdl/bms_uart_frame_receiver_core_macros.svh
// Assertion macros for the battery link frame receiver.
`ifndef BMS_UART_FRAME_RECEIVER_CORE_MACROS_SVH
`define BMS_UART_FRAME_RECEIVER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// check a property on every clock edge out of reset
`define BMSFR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// check that a condition holds in the cycle after a trigger
`define BMSFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define BMSFR_ASSERT(lbl, prop, msg)
`define BMSFR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/bmsfr_pkg.sv
// Types and constants of the battery link frame receiver.
package bmsfr_pkg;

	localparam int unsigned FRAME_LEN = 13;

	localparam logic [7:0] SOF_BYTE    = 8'hA5;
	localparam logic [7:0] ADDR_BYTE   = 8'h01;
	localparam logic [7:0] CMD_MIN     = 8'h90;
	localparam logic [7:0] CMD_MAX     = 8'h98;
	localparam logic [7:0] LEN_BYTE    = 8'd8;
	localparam logic [15:0] CUR_OFFSET = 16'd30000;
	localparam logic [12:0] TEMP_OFFSET = 13'd40;
	localparam logic [7:0] CELL_GROUPS = 8'd16;

	// frame positions
	localparam logic [3:0] POS_SOF   = 4'd0;
	localparam logic [3:0] POS_ADDR  = 4'd1;
	localparam logic [3:0] POS_CMD   = 4'd2;
	localparam logic [3:0] POS_LEN   = 4'd3;
	localparam logic [3:0] POS_DATA  = 4'd4;
	localparam logic [3:0] POS_CSUM  = 4'd12;

	// word kinds on the input tuser
	localparam logic OP_RX_BYTE   = 1'b0;
	localparam logic OP_CELL_READ = 1'b1;

	// command codes, relative to CMD_MIN
	typedef enum logic [3:0] {
		CODE_STATUS   = 4'd0,
		CODE_CELL_EXT = 4'd1,
		CODE_TEMP     = 4'd2,
		CODE_CAPACITY = 4'd3,
		CODE_CELL_V   = 4'd5,
		CODE_FAULT    = 4'd8
	} code_t;

	typedef struct packed {
		logic [1:0] pad;
		logic [5:0] cell_select;
		logic [7:0] rx_byte;
	} in_word_t;

	typedef struct packed {
		logic [15:0]        cell_mv;
		logic               fault_flag;
		logic [31:0]        capacity_mah;
		logic signed [12:0] temp_low_dc;
		logic signed [12:0] temp_high_dc;
		logic [15:0]        cell_low_mv;
		logic [15:0]        cell_high_mv;
		logic [15:0]        charge_state;
		logic signed [15:0] pack_current_da;
		logic [15:0]        pack_voltage_dv;
		logic [3:0]         frame_code;
		logic               frame_done;
	} out_word_t;

	typedef logic [2:0][15:0] cell_row_t;

endpackage

FILE: hdl/bms_uart_frame_receiver_core.sv
// Battery link frame receiver: byte checker, decoded registers and cell store.
// Path: a word accepted into the input register (s1) moves on to the result register (s2).
// Throughput: one word per cycle while the result side keeps taking words; the frame check,
// checksum and decode of one byte sit between the input register and the decoded registers, so nothing iterates.
// Reset: clears the handshake, frame position, checksum, decoded registers and the
// cell row valid bits; cell rows read as zero until written, so no clearing pass.
`include "bms_uart_frame_receiver_core_macros.svh"
module bms_uart_frame_receiver_core
	import bmsfr_pkg::*;
#(
	parameter int CELL_SLOTS = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,   // rx_byte[7:0], cell_select[13:8], zero [15:14]
	input  logic         s_tuser,   // cmd: 0 line byte, 1 cell read
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [159:0] m_tdata    // frame_done, frame_code, pack_voltage_dv,
	                                // pack_current_da, charge_state, cell_high_mv,
	                                // cell_low_mv, temp_high_dc, temp_low_dc,
	                                // capacity_mah, fault_flag, cell_mv
);

	// The cell store is kept as rows of three cells: a cell voltage frame
	// always writes one whole row, and a read fetches one row then picks a cell.
	localparam int ROWS  = (CELL_SLOTS + 2) / 3;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

	// ------------------------------------------------------------------
	// handshake: input register (s1) and result register (s2)
	// ------------------------------------------------------------------
	logic     s1_valid_q;
	logic     s2_valid_q;
	logic     op_s1;
	in_word_t word_s1;
	logic     adv_s2;
	logic     adv_s1;
	logic     s_acc;

	// s2 may load when empty or when its word is taken
	assign adv_s2   = !s2_valid_q || m_tready;
	// the word in s1 is processed in the cycle it moves into s2
	assign adv_s1   = s1_valid_q && adv_s2;
	assign s_tready = !s1_valid_q || adv_s2;
	assign s_acc    = s_tvalid && s_tready;
	assign m_tvalid = s2_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (s_acc) begin
				s1_valid_q <= 1'b1;
			end else if (adv_s1) begin
				s1_valid_q <= 1'b0;
			end
			if (adv_s2) begin
				s2_valid_q <= s1_valid_q;
			end
		end
	end

	// payload of the input register, no reset needed
	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_s1   <= s_tuser;
			word_s1 <= in_word_t'(s_tdata);
		end
	end

	// ------------------------------------------------------------------
	// frame checker
	// ------------------------------------------------------------------
	logic [3:0]  byte_count_q;
	logic [7:0]  running_sum_q;
	logic [3:0]  code_q;
	logic [7:0]  data_q [8];
	logic [3:0]  pos;
	logic [7:0]  rx_b;
	logic        is_byte;
	logic        ok;
	logic        apply;

	assign rx_b    = word_s1.rx_byte;
	assign is_byte = adv_s1 && (op_s1 == OP_RX_BYTE);
	// a position past the frame restarts at the start byte
	assign pos     = (byte_count_q >= 4'(FRAME_LEN)) ? POS_SOF : byte_count_q;

	always_comb begin
		priority if (pos == POS_SOF) begin
			ok = (rx_b == SOF_BYTE);
		end else if (pos == POS_ADDR) begin
			ok = (rx_b == ADDR_BYTE);
		end else if (pos == POS_CMD) begin
			ok = (rx_b >= CMD_MIN) && (rx_b <= CMD_MAX);
		end else if (pos == POS_LEN) begin
			ok = (rx_b == LEN_BYTE);
		end else if (pos == POS_CSUM) begin
			ok = (rx_b == running_sum_q);
		end else begin
			ok = 1'b1;
		end
	end

	assign apply = is_byte && ok && (pos == POS_CSUM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			running_sum_q <= '0;
		end else if (is_byte) begin
			if (!ok || pos == POS_CSUM) begin
				// drop the partial frame, or close a complete one
				byte_count_q  <= '0;
				running_sum_q <= '0;
			end else begin
				byte_count_q  <= pos + 4'd1;
				running_sum_q <= running_sum_q + rx_b;
			end
		end
	end

	// capture the command and data bytes as they pass
	always_ff @(posedge clk) begin
		if (is_byte && pos == POS_CMD) begin
			code_q <= 4'(rx_b - CMD_MIN);
		end
		if (is_byte && pos >= POS_DATA && pos < POS_CSUM) begin
			data_q[3'(pos - POS_DATA)] <= rx_b;
		end
	end

	// ------------------------------------------------------------------
	// decode of a complete frame
	// ------------------------------------------------------------------
	logic [3:0]         last_code_q;
	logic [15:0]        voltage_q;
	logic [15:0]        current_q;
	logic [15:0]        soc_q;
	logic [15:0]        cell_high_q;
	logic [15:0]        cell_low_q;
	logic [12:0]        temp_high_q;
	logic [12:0]        temp_low_q;
	logic [31:0]        capacity_q;
	logic               fault_q;
	logic [15:0]        soc_raw;
	logic [12:0]        th_off;
	logic [12:0]        tl_off;

	assign soc_raw = {data_q[6], data_q[7]};
	// (raw - 40) * 10 modulo 2^13, times ten as two shifts
	assign th_off  = {5'd0, data_q[0]} - TEMP_OFFSET;
	assign tl_off  = {5'd0, data_q[2]} - TEMP_OFFSET;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_code_q <= '0;
			voltage_q   <= '0;
			current_q   <= '0;
			soc_q       <= '0;
			cell_high_q <= '0;
			cell_low_q  <= '0;
			temp_high_q <= '0;
			temp_low_q  <= '0;
			capacity_q  <= '0;
			fault_q     <= 1'b0;
		end else if (apply) begin
			last_code_q <= code_q;
			unique case (code_q)
				CODE_STATUS: begin
					voltage_q <= {data_q[0], data_q[1]};
					current_q <= {data_q[4], data_q[5]} - CUR_OFFSET;
					soc_q     <= (soc_raw << 3) + (soc_raw << 1);
				end
				CODE_CELL_EXT: begin
					cell_high_q <= {data_q[0], data_q[1]};
					cell_low_q  <= {data_q[3], data_q[4]};
				end
				CODE_TEMP: begin
					temp_high_q <= (th_off << 3) + (th_off << 1);
					temp_low_q  <= (tl_off << 3) + (tl_off << 1);
				end
				CODE_CAPACITY: begin
					capacity_q <= {data_q[4], data_q[5], data_q[6], data_q[7]};
				end
				CODE_FAULT: begin
					fault_q <= |{data_q[0], data_q[1], data_q[2], data_q[3],
					             data_q[4], data_q[5], data_q[6], data_q[7]};
				end
				default: begin
					// other commands only move the frame code
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// cell store
	// ------------------------------------------------------------------
	cell_row_t         cell_mem [ROWS];
	logic [ROWS-1:0]   row_valid_q;
	logic [3:0]        grp;
	logic              wr_en;
	logic [ROW_W-1:0]  wr_row;
	cell_row_t         wr_data;
	logic [12:0]       sel_prod;
	logic [5:0]        sel_row;
	logic [5:0]        sel_bank;
	logic              sel_ok;
	logic [ROW_W-1:0]  rd_row;
	logic              rd_hit;
	cell_row_t         rd_row_s2;
	cell_row_t         byp_row_s2;
	logic              byp_s2;
	logic              cell_ok_s2;
	logic [1:0]        bank_s2;
	logic              frame_done_s2;
	cell_row_t         out_row;
	logic [15:0]       cell_val;

	assign grp     = 4'(data_q[0] - 8'd1);
	// group 1..16 maps to row 0..15, rows past the store are not written
	assign wr_en   = apply && (code_q == CODE_CELL_V) && (data_q[0] >= 8'd1)
	                 && (data_q[0] <= CELL_GROUPS) && ({2'b00, grp} < 6'(ROWS));
	assign wr_row  = ROW_W'(grp);
	assign wr_data = {{data_q[5], data_q[6]}, {data_q[3], data_q[4]},
	                  {data_q[1], data_q[2]}};

	// cell_select / 3 by reciprocal, exact for six-bit values
	assign sel_prod = 13'(word_s1.cell_select) * 13'd43;
	assign sel_row  = sel_prod[12:7];
	assign sel_bank = word_s1.cell_select - ((sel_row << 1) + sel_row);
	assign sel_ok   = (7'(word_s1.cell_select) < 7'(CELL_SLOTS));
	assign rd_row   = sel_ok ? ROW_W'(sel_row) : '0;
	assign rd_hit   = wr_en && (wr_row == rd_row);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cell_mem[wr_row] <= wr_data;
		end
		if (adv_s1) begin
			rd_row_s2 <= cell_mem[rd_row];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
		end else if (wr_en) begin
			row_valid_q[wr_row] <= 1'b1;
		end
	end

	// result side of the read; a write in the same cycle is forwarded
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			byp_s2        <= rd_hit;
			byp_row_s2    <= wr_data;
			cell_ok_s2    <= sel_ok && (row_valid_q[rd_row] || rd_hit);
			bank_s2       <= sel_bank[1:0];
			frame_done_s2 <= apply;
		end
	end

	assign out_row = byp_s2 ? byp_row_s2 : rd_row_s2;

	always_comb begin
		unique case (bank_s2)
			2'd0:    cell_val = out_row[0];
			2'd1:    cell_val = out_row[1];
			2'd2:    cell_val = out_row[2];
			default: cell_val = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// result word; decoded registers only move when s2 reloads
	// ------------------------------------------------------------------
	out_word_t res;

	always_comb begin
		res.frame_done      = frame_done_s2;
		res.frame_code      = last_code_q;
		res.pack_voltage_dv = voltage_q;
		res.pack_current_da = current_q;
		res.charge_state    = soc_q;
		res.cell_high_mv    = cell_high_q;
		res.cell_low_mv     = cell_low_q;
		res.temp_high_dc    = temp_high_q;
		res.temp_low_dc     = temp_low_q;
		res.capacity_mah    = capacity_q;
		res.fault_flag      = fault_q;
		res.cell_mv         = cell_ok_s2 ? cell_val : 16'd0;
	end

	assign m_tdata = res;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	`BMSFR_ASSERT(a_pos_range, byte_count_q < 4'(FRAME_LEN), "frame position out of range")
	`BMSFR_ASSERT(a_done_restart, s2_valid_q && frame_done_s2 |-> byte_count_q == '0 && running_sum_q == '0, "frame not restarted after completion")
	`BMSFR_ASSERT_NEXT(a_hold_state, !adv_s1, $stable(byte_count_q) && $stable(running_sum_q) && $stable(last_code_q), "state moved without a processed word")
	`BMSFR_ASSERT_NEXT(a_rows_sticky, 1'b1, (row_valid_q & $past(row_valid_q)) == $past(row_valid_q), "cell row valid bit cleared")

endmodule

FILE: verif/bmsfr_telemetry_checker.sv
// Checker for the battery link frame receiver: predicts each result word and compares it.
`timescale 1ns / 1ps
module bmsfr_telemetry_checker
	import bmsfr_pkg::*;
#(
	parameter int CELL_SLOTS = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [15:0]  s_tdata,   // rx_byte[7:0], cell_select[13:8], zero [15:14]
	input  logic         s_tuser,   // cmd
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [159:0] m_tdata,   // out_word_t, frame_done in bit 0
	output int           fail_count,
	output int           pending
);

	logic [7:0]  frame_buf [0:FRAME_LEN-1];
	logic [3:0]  byte_pos;
	logic [7:0]  csum_acc;
	logic [3:0]  code_q;
	logic [15:0] voltage_q;
	logic [15:0] current_q;
	logic [15:0] soc_q;
	logic [15:0] cell_high_q;
	logic [15:0] cell_low_q;
	logic [12:0] temp_high_q;
	logic [12:0] temp_low_q;
	logic [31:0] capacity_q;
	logic        fault_q;
	logic [15:0] cell_mem [0:CELL_SLOTS-1];
	out_word_t   telemetry_q [$];
	out_word_t   want;
	out_word_t   got;
	int          n_fail;
	int          n_seen;

	// Advance the link state by one word and return the register view after it.
	function automatic out_word_t absorb_word(input logic op, input in_word_t w);
		out_word_t  r;
		logic [7:0] d [0:7];
		logic [3:0] pos;
		logic [7:0] base;
		logic       ok;
		logic       done;
		done = 1'b0;
		if (op == OP_RX_BYTE) begin
			pos = (byte_pos >= FRAME_LEN) ? POS_SOF : byte_pos;
			frame_buf[pos] = w.rx_byte;
			case (pos)
				POS_SOF:  ok = (w.rx_byte == SOF_BYTE);
				POS_ADDR: ok = (w.rx_byte == ADDR_BYTE);
				POS_CMD:  ok = (w.rx_byte >= CMD_MIN) && (w.rx_byte <= CMD_MAX);
				POS_LEN:  ok = (w.rx_byte == LEN_BYTE);
				POS_CSUM: ok = (w.rx_byte == csum_acc);
				default:  ok = 1'b1;
			endcase
			if (!ok) begin
				byte_pos = POS_SOF;
				csum_acc = 8'd0;
			end else if (pos == POS_CSUM) begin
				for (int k = 0; k < 8; k++)
					d[k] = frame_buf[POS_DATA + k];
				code_q = 4'(frame_buf[POS_CMD] - CMD_MIN);
				case (code_q)
					CODE_STATUS: begin
						voltage_q = {d[0], d[1]};
						current_q = {d[4], d[5]} - CUR_OFFSET;
						soc_q     = {d[6], d[7]} * 16'd10;
					end
					CODE_CELL_EXT: begin
						cell_high_q = {d[0], d[1]};
						cell_low_q  = {d[3], d[4]};
					end
					CODE_TEMP: begin
						temp_high_q = ({5'd0, d[0]} - TEMP_OFFSET) * 13'd10;
						temp_low_q  = ({5'd0, d[2]} - TEMP_OFFSET) * 13'd10;
					end
					CODE_CAPACITY: capacity_q = {d[4], d[5], d[6], d[7]};
					CODE_CELL_V: begin
						// a group outside 1..16 leaves the store alone
						if (d[0] >= 8'd1 && d[0] <= CELL_GROUPS) begin
							base = (d[0] - 8'd1) * 8'd3;
							for (int k = 0; k < 3; k++)
								if (int'(base) + k < CELL_SLOTS)
									cell_mem[int'(base) + k] = {d[1 + 2*k], d[2 + 2*k]};
						end
					end
					CODE_FAULT: fault_q = |{d[0], d[1], d[2], d[3], d[4], d[5], d[6], d[7]};
					default: ;
				endcase
				done     = 1'b1;
				byte_pos = POS_SOF;
				csum_acc = 8'd0;
			end else begin
				csum_acc = csum_acc + w.rx_byte;
				byte_pos = pos + 4'd1;
			end
		end
		r.frame_done      = done;
		r.frame_code      = code_q;
		r.pack_voltage_dv = voltage_q;
		r.pack_current_da = current_q;
		r.charge_state    = soc_q;
		r.cell_high_mv    = cell_high_q;
		r.cell_low_mv     = cell_low_q;
		r.temp_high_dc    = temp_high_q;
		r.temp_low_dc     = temp_low_q;
		r.capacity_mah    = capacity_q;
		r.fault_flag      = fault_q;
		r.cell_mv         = (w.cell_select < CELL_SLOTS) ? cell_mem[w.cell_select] : 16'd0;
		return r;
	endfunction

	function automatic void show_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v)
			$display("  %s: expected %0h, got %0h", name, exp_v, act_v);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos    = POS_SOF;
			csum_acc    = 8'd0;
			code_q      = 4'd0;
			voltage_q   = 16'd0;
			current_q   = 16'd0;
			soc_q       = 16'd0;
			cell_high_q = 16'd0;
			cell_low_q  = 16'd0;
			temp_high_q = 13'd0;
			temp_low_q  = 13'd0;
			capacity_q  = 32'd0;
			fault_q     = 1'b0;
			for (int k = 0; k < CELL_SLOTS; k++)
				cell_mem[k] = 16'd0;
			telemetry_q.delete();
			n_fail      = 0;
			n_seen      = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// retire the output word first: it belongs to an older input word
			if (m_tvalid && m_tready) begin
				n_seen++;
				got = out_word_t'(m_tdata);
				if (telemetry_q.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display("result %0d arrived with nothing outstanding: %h", n_seen,
							m_tdata);
				end else begin
					want = telemetry_q.pop_front();
					if (got !== want) begin
						n_fail++;
						if (n_fail <= 10) begin
							$display("result %0d differs at %0t", n_seen, $realtime);
							show_field("frame_done", want.frame_done, got.frame_done);
							show_field("frame_code", want.frame_code, got.frame_code);
							show_field("pack_voltage_dv", want.pack_voltage_dv,
								got.pack_voltage_dv);
							show_field("pack_current_da", want.pack_current_da,
								got.pack_current_da);
							show_field("charge_state", want.charge_state, got.charge_state);
							show_field("cell_high_mv", want.cell_high_mv, got.cell_high_mv);
							show_field("cell_low_mv", want.cell_low_mv, got.cell_low_mv);
							show_field("temp_high_dc", want.temp_high_dc, got.temp_high_dc);
							show_field("temp_low_dc", want.temp_low_dc, got.temp_low_dc);
							show_field("capacity_mah", want.capacity_mah, got.capacity_mah);
							show_field("fault_flag", want.fault_flag, got.fault_flag);
							show_field("cell_mv", want.cell_mv, got.cell_mv);
						end
					end
				end
			end
			if (s_tvalid && s_tready)
				telemetry_q.push_back(absorb_word(s_tuser, in_word_t'(s_tdata)));
			fail_count <= n_fail;
			pending    <= telemetry_q.size();
		end
	end

endmodule

FILE: verif/tb.sv
// Top of the frame receiver testbench: clock, reset, word traffic and the final verdict.
`timescale 1ns / 1ps
module tb
	import bmsfr_pkg::*;
();

	localparam int CELL_SLOTS  = 48;
	// longest stretch the receiver holds off on purpose
	localparam int LONG_HOLD   = 400;
	// cycles without any word moving before the run is declared hung
	localparam int QUIET_LIMIT = 4000;

	// ways to damage a frame
	localparam int FLAW_NONE    = 0;
	localparam int FLAW_CORRUPT = 1;
	localparam int FLAW_CUT     = 2;

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [15:0]  s_tdata  = 16'd0;   // rx_byte[7:0], cell_select[13:8], zero [15:14]
	logic         s_tuser  = OP_RX_BYTE;   // cmd: 0 line byte, 1 cell read
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [159:0] m_tdata;              // frame_done, frame_code, ... cell_mv (out_word_t)

	int send_idle_pct = 12;
	int recv_idle_pct = 54;
	logic stall_arm   = 1'b0;
	logic stall_taken = 1'b0;
	int hold_left     = 0;
	int quiet_cycles  = 0;
	int words_sent    = 0;
	int fail_count;
	int pending;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	bms_uart_frame_receiver_core #(
		.CELL_SLOTS(CELL_SLOTS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	bmsfr_telemetry_checker #(
		.CELL_SLOTS(CELL_SLOTS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Result side: random back-pressure, plus one long hold-off once armed.
	// The hold is counted here so the sender keeps offering words meanwhile
	// and the block has to fill up and stall its input.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (stall_arm && !stall_taken) begin
			stall_taken <= 1'b1;
			hold_left   <= LONG_HOLD;
			m_tready    <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog: reset the count whenever a word moves on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("bms_uart_frame_receiver_core: mismatch");
			$finish;
		end
	end

	// Offer one word, with an optional random gap first; return at the edge
	// that accepts it. tvalid stays high so back-to-back words need no gap.
	task automatic send_word(input logic op, input logic [7:0] b, input logic [5:0] sel);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= in_word_t'{pad: 2'b00, cell_select: sel, rx_byte: b};
		s_tuser  <= op;
		do
			@(posedge clk);
		while (!s_tready);
		words_sent++;
	endtask

	// Mostly valid cells; now and then a select beyond the store, which reads zero.
	function automatic logic [5:0] pick_cell();
		if ($urandom_range(15) == 0)
			return 6'($urandom_range(63, CELL_SLOTS));
		return 6'($urandom_range(CELL_SLOTS - 1));
	endfunction

	// Lean data bytes toward the extremes so wrap and sign cases show up.
	function automatic logic [7:0] pick_data();
		case ($urandom_range(3))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Build a frame with a correct checksum, then damage it if asked.
	// Cell reads drop in between line bytes; they must not disturb matching.
	task automatic send_frame(input logic [3:0] code, input logic [63:0] data, input int flaw);
		logic [7:0] fb [0:FRAME_LEN-1];
		logic [7:0] sum;
		int         bad_pos;
		int         stop_at;
		fb[POS_SOF]  = SOF_BYTE;
		fb[POS_ADDR] = ADDR_BYTE;
		fb[POS_CMD]  = CMD_MIN + code;
		fb[POS_LEN]  = LEN_BYTE;
		for (int k = 0; k < 8; k++)
			fb[POS_DATA + k] = data[63 - 8*k -: 8];
		sum = 8'd0;
		for (int k = 0; k < POS_CSUM; k++)
			sum = sum + fb[k];
		fb[POS_CSUM] = sum;
		stop_at = FRAME_LEN;
		if (flaw == FLAW_CORRUPT) begin
			bad_pos = $urandom_range(FRAME_LEN - 1);
			fb[bad_pos] = fb[bad_pos] ^ 8'($urandom_range(255, 1));
		end else if (flaw == FLAW_CUT) begin
			stop_at = $urandom_range(FRAME_LEN - 1, 1);
		end
		for (int k = 0; k < stop_at; k++) begin
			if ($urandom_range(9) == 0)
				send_word(OP_CELL_READ, 8'($urandom), pick_cell());
			send_word(OP_RX_BYTE, fb[k], pick_cell());
		end
	endtask

	// Random traffic up to a word count: mostly good frames with random
	// content, some damaged or cut short, some line noise.
	task automatic run_traffic(input int upto);
		int          pick;
		logic [3:0]  code;
		logic [63:0] data;
		while (words_sent < upto) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				repeat ($urandom_range(6, 1))
					send_word(($urandom_range(3) == 0) ? OP_CELL_READ : OP_RX_BYTE,
						($urandom_range(7) == 0) ? SOF_BYTE : 8'($urandom), pick_cell());
			end else begin
				// favor the cell group frame: it is the only one that fills the store
				code = ($urandom_range(3) == 0) ? CODE_CELL_V : 4'($urandom_range(8));
				for (int k = 0; k < 8; k++)
					data[63 - 8*k -: 8] = pick_data();
				if (code == CODE_CELL_V) begin
					if ($urandom_range(5) == 0)
						data[63:56] = $urandom_range(1) ? 8'h00 : 8'($urandom_range(255, 17));
					else
						data[63:56] = 8'($urandom_range(16, 1));
				end
				send_frame(code, data,
					(pick < 20) ? FLAW_CORRUPT : (pick < 26) ? FLAW_CUT : FLAW_NONE);
			end
		end
	endtask

	// Hold the sender until every outstanding result word has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reads of a cleared store, a select beyond the store,
		// stray line bytes at both extremes, the top cell group, read back.
		send_word(OP_CELL_READ, 8'hFF, 6'd0);
		send_word(OP_CELL_READ, 8'h00, 6'd63);
		send_word(OP_RX_BYTE, 8'h00, 6'd63);
		send_word(OP_RX_BYTE, 8'hFF, 6'd0);
		send_frame(CODE_CELL_V, 64'h10FF_FF00_0012_3400, FLAW_NONE);
		send_word(OP_CELL_READ, 8'h5A, 6'd45);
		send_word(OP_CELL_READ, 8'hA5, 6'd47);

		// light sender gaps, heavy back-pressure
		run_traffic(450);
		wait_drained();

		// heavy sender gaps, light back-pressure
		send_idle_pct <= 54;
		recv_idle_pct <= 12;
		run_traffic(880);
		wait_drained();

		// full rate on both sides, with one long hold-off on the result side
		send_idle_pct <= 0;
		recv_idle_pct <= 0;
		stall_arm     <= 1'b1;
		run_traffic(1300);
		wait_drained();

		// let any stray result word show up before the verdict
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("bms_uart_frame_receiver_core: match");
		else
			$display("bms_uart_frame_receiver_core: mismatch");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+hdl
hdl/bmsfr_pkg.sv
hdl/bms_uart_frame_receiver_core.sv
verif/bmsfr_telemetry_checker.sv
verif/tb.sv
